/* sv/sc8_pkg.sv */
// Shared types and constants for the sc16 to sc8 scale and pack unit.
package sc8_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 24;
    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 32;

    // Defaults for top-level parameters
    localparam int GAIN_FRAC_BITS_DEF = 24;
    localparam int QUEUE_DEPTH_DEF    = 4;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_GAIN = 1'b0,
        REG_SWAP = 1'b1
    } reg_idx_t;

    // One completed pair of scaled samples, queued between front and back
    typedef struct packed {
        logic [BYTE_W-1:0] re0;
        logic [BYTE_W-1:0] im0;
        logic [BYTE_W-1:0] re1;
        logic [BYTE_W-1:0] im1;
        logic              ovf;
        logic              last;
    } pair_t;

endpackage

/* sv/sc8_ifs.sv */
// Valid/ready channel interfaces for complex samples and packed words.
interface sc8_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [sc8_pkg::SAMPLE_W-1:0] real_part;
    logic signed [sc8_pkg::SAMPLE_W-1:0] imag_part;
    logic                                final_sample;

    modport source (output valid, real_part, imag_part, final_sample, input ready);
    modport sink   (input valid, real_part, imag_part, final_sample, output ready);
endinterface

interface sc8_word_if;
    logic                          valid;
    logic                          ready;
    logic [sc8_pkg::WORD_W-1:0]    packed_word;
    logic                          overflow;
    logic                          final_word;

    modport source (output valid, packed_word, overflow, final_word, input ready);
    modport sink   (input valid, packed_word, overflow, final_word, output ready);
endinterface

/* sv/sc16_to_sc8_scale_pack_unit.sv */
// Top level of the sc16 to sc8 scale and pack unit with its register port.
// Throughput: one sample per cycle while queue credit allows, one packed
// word per two samples or per unpaired final sample. A word is valid in the
// output register once its last sample has passed stage 1 and the queue.
// The pipeline is multiply stage, round/pair stage, queue, output register.
// Reset (rst_n low, asynchronous) clears gain, swap order, held sample,
// queue and output valid.
module sc16_to_sc8_scale_pack_unit #(
    parameter int GAIN_FRAC_BITS = sc8_pkg::GAIN_FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH    = sc8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sc8_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sc8_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sc8_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    sc8_sample_if.sink                     sample_in,
    sc8_word_if.source                     word_out
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [sc8_pkg::GAIN_W-1:0] gain_reg;
    logic                       swap_reg;
    logic                       cfg_write;
    sc8_pkg::reg_idx_t          reg_idx;

    logic                       push;
    sc8_pkg::pair_t             push_data;
    logic                       pop;
    sc8_pkg::pair_t             pop_data;
    logic [CNT_W-1:0]           q_count;

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = sc8_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= '0;
            swap_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                sc8_pkg::REG_GAIN: gain_reg <= pwdata[sc8_pkg::GAIN_W-1:0];
                sc8_pkg::REG_SWAP: swap_reg <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            sc8_pkg::REG_GAIN: prdata = sc8_pkg::APB_DATA_W'(gain_reg);
            sc8_pkg::REG_SWAP: prdata = sc8_pkg::APB_DATA_W'(swap_reg);
            default:           prdata = '0;
        endcase
    end

    sc8_front #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .QUEUE_DEPTH    (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (sample_in),
        .gain      (gain_reg),
        .q_count   (q_count),
        .push      (push),
        .push_data (push_data)
    );

    sc8_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .count     (q_count)
    );

    sc8_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .swap_order (swap_reg),
        .pop_data   (pop_data),
        .q_count    (q_count),
        .pop        (pop),
        .word_out   (word_out)
    );

endmodule

/* sv/sc8_front.sv */
// Front end: accepts samples, scales and rounds both lanes, pairs samples.
module sc8_front #(
    parameter int GAIN_FRAC_BITS = sc8_pkg::GAIN_FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH    = sc8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    sc8_sample_if.sink                    sample_in,
    input  logic [sc8_pkg::GAIN_W-1:0]    gain,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count,
    output logic                          push,
    output sc8_pkg::pair_t                push_data
);

    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int MAG_W  = sc8_pkg::SAMPLE_W + 1;
    localparam int PROD_W = MAG_W + sc8_pkg::GAIN_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int BYTE_W = sc8_pkg::BYTE_W;

    // Rounds a magnitude product half away from zero, wraps to a byte.
    // Returns {overflow, byte}.
    function automatic logic [BYTE_W:0] round_lane(input logic [PROD_W-1:0] prod,
                                                   input logic neg);
        logic [SUM_W-1:0]  sum;
        logic [SUM_W-1:0]  q;
        logic [BYTE_W-1:0] lane_byte;
        logic              lane_ovf;
        sum = {1'b0, prod} + (SUM_W'(1) << (GAIN_FRAC_BITS - 1));
        q   = sum >> GAIN_FRAC_BITS;
        if (neg)
        begin
            lane_ovf  = (q > SUM_W'(128));
            lane_byte = BYTE_W'(8'd0 - q[BYTE_W-1:0]);
        end
        else
        begin
            lane_ovf  = (q > SUM_W'(127));
            lane_byte = q[BYTE_W-1:0];
        end
        return {lane_ovf, lane_byte};
    endfunction

    logic              accept;
    logic [MAG_W-1:0]  re_mag;
    logic [MAG_W-1:0]  im_mag;

    logic              s1_valid_reg;
    logic [PROD_W-1:0] s1_re_prod_reg;
    logic [PROD_W-1:0] s1_im_prod_reg;
    logic              s1_re_neg_reg;
    logic              s1_im_neg_reg;
    logic              s1_last_reg;

    logic [BYTE_W:0]   re_res;
    logic [BYTE_W:0]   im_res;
    logic              cur_ovf;

    logic              held_valid_reg;
    logic              held_valid_next;
    logic [BYTE_W-1:0] held_re_reg;
    logic [BYTE_W-1:0] held_im_reg;
    logic              held_ovf_reg;
    logic              hold_load;

    // Credit check: queue space for everything that may still arrive
    assign sample_in.ready = ({1'b0, q_count} + (CNT_W + 1)'(s1_valid_reg))
                             < (CNT_W + 1)'(QUEUE_DEPTH);
    assign accept = sample_in.valid && sample_in.ready;

    // Sign-magnitude split of both lanes
    always_comb
    begin
        re_mag = sample_in.real_part[sc8_pkg::SAMPLE_W-1]
               ? MAG_W'((MAG_W'(1) << sc8_pkg::SAMPLE_W) - {1'b0, sample_in.real_part})
               : {1'b0, sample_in.real_part};
        im_mag = sample_in.imag_part[sc8_pkg::SAMPLE_W-1]
               ? MAG_W'((MAG_W'(1) << sc8_pkg::SAMPLE_W) - {1'b0, sample_in.imag_part})
               : {1'b0, sample_in.imag_part};
    end

    // Stage 1: multiply by gain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_re_prod_reg <= PROD_W'(re_mag * gain);
            s1_im_prod_reg <= PROD_W'(im_mag * gain);
            s1_re_neg_reg  <= sample_in.real_part[sc8_pkg::SAMPLE_W-1];
            s1_im_neg_reg  <= sample_in.imag_part[sc8_pkg::SAMPLE_W-1];
            s1_last_reg    <= sample_in.final_sample;
        end
    end

    // Stage 2: round, wrap, pair
    assign re_res  = round_lane(s1_re_prod_reg, s1_re_neg_reg);
    assign im_res  = round_lane(s1_im_prod_reg, s1_im_neg_reg);
    assign cur_ovf = re_res[BYTE_W] || im_res[BYTE_W];

    always_comb
    begin
        push            = 1'b0;
        hold_load       = 1'b0;
        held_valid_next = held_valid_reg;
        push_data       = '0;
        if (s1_valid_reg)
        begin
            if (held_valid_reg)
            begin
                push            = 1'b1;
                held_valid_next = 1'b0;
                push_data.re0   = held_re_reg;
                push_data.im0   = held_im_reg;
                push_data.re1   = re_res[BYTE_W-1:0];
                push_data.im1   = im_res[BYTE_W-1:0];
                push_data.ovf   = held_ovf_reg || cur_ovf;
                push_data.last  = s1_last_reg;
            end
            else if (s1_last_reg)
            begin
                // unpaired final sample: pad with a zero sample
                push            = 1'b1;
                push_data.re0   = re_res[BYTE_W-1:0];
                push_data.im0   = im_res[BYTE_W-1:0];
                push_data.ovf   = cur_ovf;
                push_data.last  = 1'b1;
            end
            else
            begin
                hold_load       = 1'b1;
                held_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_valid_reg <= 1'b0;
        else
            held_valid_reg <= held_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (hold_load)
        begin
            held_re_reg  <= re_res[BYTE_W-1:0];
            held_im_reg  <= im_res[BYTE_W-1:0];
            held_ovf_reg <= cur_ovf;
        end
    end

endmodule

/* sv/sc8_queue.sv */
// Small FIFO of completed sample pairs between front and back.
module sc8_queue #(
    parameter int QUEUE_DEPTH = sc8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  sc8_pkg::pair_t                   push_data,
    input  logic                             pop,
    output sc8_pkg::pair_t                   pop_data,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    sc8_pkg::pair_t   mem_reg [QUEUE_DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg;
    logic [IDX_W-1:0] wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [IDX_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                        : IDX_W'(wr_ptr_reg + 1'b1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                        : IDX_W'(rd_ptr_reg + 1'b1);
        if (push && !pop)
            count_next = CNT_W'(count_reg + 1'b1);
        else if (pop && !push)
            count_next = CNT_W'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    assign pop_data = mem_reg[rd_ptr_reg];
    assign count    = count_reg;

    // Credit scheme must keep the queue from overrunning
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CNT_W'(QUEUE_DEPTH)) || pop)
        else $error("queue push while full");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue pop while empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("queue count lost a push");

endmodule

/* sv/sc8_back.sv */
// Back end: packs queued pairs into words and holds the output register.
module sc8_back #(
    parameter int QUEUE_DEPTH = sc8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             swap_order,
    input  sc8_pkg::pair_t                   pop_data,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count,
    output logic                             pop,
    sc8_word_if.source                       word_out
);

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [sc8_pkg::WORD_W-1:0] word_reg;
    logic                       ovf_reg;
    logic                       last_reg;
    logic [sc8_pkg::WORD_W-1:0] word_packed;

    // Load output register when it is empty or being taken
    assign pop = (q_count != '0) && (!out_valid_reg || word_out.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = 1'b1;
        else if (word_out.ready)
            out_valid_next = 1'b0;
    end

    // Byte layout
    always_comb
    begin
        if (swap_order)
            word_packed = {pop_data.im0, pop_data.re0, pop_data.im1, pop_data.re1};
        else
            word_packed = {pop_data.re1, pop_data.im1, pop_data.re0, pop_data.im0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            word_reg <= word_packed;
            ovf_reg  <= pop_data.ovf;
            last_reg <= pop_data.last;
        end
    end

    assign word_out.valid       = out_valid_reg;
    assign word_out.packed_word = word_reg;
    assign word_out.overflow    = ovf_reg;
    assign word_out.final_word  = last_reg;

endmodule

/* dv/sc16_to_sc8_scale_pack_unit_test.sv */
// Testbench for the sc16 to sc8 scale and pack unit: random traffic checked against a predictor.
`timescale 1ns / 1ps

module sc16_to_sc8_scale_pack_unit_test;

    localparam int FRAC_BITS = sc8_pkg::GAIN_FRAC_BITS_DEF;
    localparam int PHASES    = 7;
    localparam int PHASE_LEN = 165;
    localparam int SAMPLE_W  = sc8_pkg::SAMPLE_W;
    localparam int GAIN_W    = sc8_pkg::GAIN_W;
    localparam int BYTE_W    = sc8_pkg::BYTE_W;
    localparam int WORD_W    = sc8_pkg::WORD_W;
    localparam int DATA_W    = sc8_pkg::APB_DATA_W;

    // One expected packed-word transaction
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              ovf;
        logic              fin;
    } packed_result_t;

    // Tracks gain, byte order and the held half-pair; queues the words the unit owes us
    class pack_scoreboard_t;
        bit [GAIN_W-1:0]  gain;
        bit               swap;
        bit               held;
        bit [BYTE_W-1:0]  held_re;
        bit [BYTE_W-1:0]  held_im;
        bit               held_ovf;
        packed_result_t   pending_words[$];
        int               errors;
        int               samples_seen;

        function void set_register(sc8_pkg::reg_idx_t idx, logic [DATA_W-1:0] value);
            if (idx == sc8_pkg::REG_GAIN)
                gain = value[GAIN_W-1:0];
            else
                swap = value[0];
        endfunction

        // Scale one lane, round half away from zero, keep the low byte
        function logic [BYTE_W-1:0] scale_to_byte(logic signed [SAMPLE_W-1:0] raw,
                                                  inout bit ovf);
            longint unsigned mag;
            longint unsigned q;
            bit neg;
            neg = raw[SAMPLE_W-1];
            mag = neg ? -int'(raw) : int'(raw);
            q = (mag * gain + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            if (neg)
            begin
                if (q > 128)
                    ovf = 1'b1;
                return 8'(64'd0 - q);
            end
            if (q > 127)
                ovf = 1'b1;
            return 8'(q);
        endfunction

        // Byte layout of the word; s0 is the first sample of the pair
        function logic [WORD_W-1:0] arrange_bytes(logic [BYTE_W-1:0] r0, i0, r1, i1);
            if (swap)
                return {i0, r0, i1, r1};
            return {r1, i1, r0, i0};
        endfunction

        // Accepted input sample: pair it up or hold it
        function void note_sample(logic signed [SAMPLE_W-1:0] re, im, logic fin);
            bit ovf;
            logic [BYTE_W-1:0] rb;
            logic [BYTE_W-1:0] ib;
            packed_result_t rec;
            ovf = 1'b0;
            rb = scale_to_byte(re, ovf);
            ib = scale_to_byte(im, ovf);
            samples_seen++;
            if (held)
            begin
                rec.word = arrange_bytes(held_re, held_im, rb, ib);
                rec.ovf  = held_ovf | ovf;
                rec.fin  = fin;
                pending_words.push_back(rec);
                held     = 1'b0;
                held_re  = '0;
                held_im  = '0;
                held_ovf = 1'b0;
            end
            else if (fin)
            begin
                // unpaired last sample: pad with a zero sample
                rec.word = arrange_bytes(rb, ib, 8'h00, 8'h00);
                rec.ovf  = ovf;
                rec.fin  = 1'b1;
                pending_words.push_back(rec);
            end
            else
            begin
                held     = 1'b1;
                held_re  = rb;
                held_im  = ib;
                held_ovf = ovf;
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        // Accepted output word against the oldest expectation
        task check_word(logic [WORD_W-1:0] word, logic ovf, logic fin);
            packed_result_t want;
            if (pending_words.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word %h ovf %b final %b", word, ovf, fin));
                return;
            end
            want = pending_words.pop_front();
            if (word !== want.word)
                report_mismatch($sformatf("packed_word %h, want %h", word, want.word));
            if (ovf !== want.ovf)
                report_mismatch($sformatf("overflow %b, want %b (word %h)", ovf, want.ovf,
                                          want.word));
            if (fin !== want.fin)
                report_mismatch($sformatf("final_word %b, want %b (word %h)", fin, want.fin,
                                          want.word));
        endtask
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [sc8_pkg::APB_ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]                 pwdata;
    logic [DATA_W-1:0]                 prdata;
    logic                              pready;
    logic                              hold_off;

    sc8_sample_if sample_ch();
    sc8_word_if   word_ch();

    pack_scoreboard_t sb = new();

    sc16_to_sc8_scale_pack_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .sample_in (sample_ch),
        .word_out  (word_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Register write: setup cycle, access cycle, done when pready is seen; then read back
    task automatic write_register(input sc8_pkg::reg_idx_t idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] want;
        want = (idx == sc8_pkg::REG_GAIN) ? DATA_W'(value[GAIN_W-1:0]) : DATA_W'(value[0]);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_register(idx, value);
        @(negedge clk);
        if (prdata !== want)
            sb.report_mismatch($sformatf("register read %h, want %h", prdata, want));
        @(posedge clk);
    endtask

    // One input transaction; leaves valid high so a back-to-back item needs no gap
    task automatic send_sample(input int re, im, input logic fin, input bit steady);
        int gap;
        gap = (steady || hold_off) ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.real_part    <= SAMPLE_W'(re);
        sample_ch.imag_part    <= SAMPLE_W'(im);
        sample_ch.final_sample <= fin;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        sb.note_sample(SAMPLE_W'(re), SAMPLE_W'(im), fin);
    endtask

    // Lane values: full range, around zero, extremes, near rounding half points
    function automatic logic [SAMPLE_W-1:0] pick_lane();
        int v;
        case ($urandom_range(0, 5))
            0, 1: return 16'($urandom);
            2:
            begin
                v = $urandom_range(0, 1200);
                return 16'(v - 600);
            end
            3:
            begin
                case ($urandom_range(0, 5))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    3: return 16'hFFFF;
                    4: return 16'h8001;
                    default: return 16'h0001;
                endcase
            end
            default:
            begin
                v = $urandom_range(0, 511);
                v = (v - 256) * 128 + $urandom_range(0, 2) - 1;
                return 16'(v);
            end
        endcase
    endfunction

    // Buffers of random length, last sample marked; a phase may end mid-buffer
    task automatic stream_samples(input int count);
        int len;
        bit steady;
        while (count > 0)
        begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 16);
            steady = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < len && count > 0; k++)
            begin
                send_sample(pick_lane(), pick_lane(), k == len - 1, steady);
                count--;
            end
        end
    endtask

    // Drain before touching registers; a held sample may still be in the multiply stage
    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        while (sb.pending_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Output side: check each transaction, then draw the next stall
    initial
    begin
        int rx_wait;
        bit steady;
        int taken;
        rx_wait = 0;
        steady = 1'b0;
        taken = 0;
        word_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && word_ch.valid && word_ch.ready)
            begin
                sb.check_word(word_ch.packed_word, word_ch.overflow, word_ch.final_word);
                taken++;
                if (taken % 40 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                rx_wait = steady ? 0 : $urandom_range(0, 6);
            end
            if (rx_wait > 0)
            begin
                word_ch.ready <= 1'b0;
                rx_wait--;
            end
            else
                word_ch.ready <= !hold_off;
        end
    end

    // Long output hold-offs while input keeps coming, to back the unit up
    initial
    begin
        hold_off = 1'b0;
        while (sb.samples_seen < 350)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (90) @(posedge clk);
        hold_off <= 1'b0;
        while (sb.samples_seen < 800)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (120) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Main sequence
    initial
    begin
        logic [GAIN_W-1:0] phase_gain [PHASES];
        bit                phase_swap [PHASES];

        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.real_part    = '0;
        sample_ch.imag_part    = '0;
        sample_ch.final_sample = 1'b0;

        phase_gain[0] = 24'h010000;
        phase_swap[0] = 1'b1;
        phase_gain[1] = 24'hFFFFFF;
        phase_swap[1] = 1'b0;
        phase_gain[2] = 24'h000000;
        phase_swap[2] = 1'b1;
        phase_gain[3] = 24'($urandom);
        phase_swap[3] = 1'($urandom);
        phase_gain[4] = 24'h008000 + 24'($urandom_range(0, 255));
        phase_swap[4] = 1'b0;
        phase_gain[5] = 24'($urandom_range(24'h020000, 24'hFFFFFF));
        phase_swap[5] = 1'b1;
        phase_gain[6] = 24'h010000;
        phase_swap[6] = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unity mapping of 16-bit onto 8-bit; upper register bits must be ignored
        write_register(sc8_pkg::REG_GAIN, ($urandom & 32'hFF00_0000) | 32'h0001_0000);
        write_register(sc8_pkg::REG_SWAP, $urandom & 32'hFFFF_FFFE);

        // Directed: extremes, rounding at half points, overflow, pairing and padding
        send_sample(32767, -32768, 1'b0, 1'b0);
        send_sample(0, -1, 1'b0, 1'b0);
        send_sample(128, -128, 1'b0, 1'b0);
        send_sample(127, -127, 1'b0, 1'b0);
        send_sample(384, -384, 1'b1, 1'b0);
        send_sample(-32640, 32639, 1'b0, 1'b0);
        send_sample(32640, -32641, 1'b1, 1'b0);
        send_sample(-32767, 1, 1'b1, 1'b0);
        send_sample(32767, 32767, 1'b1, 1'b0);
        send_sample(-1, 1, 1'b0, 1'b1);
        send_sample(0, 0, 1'b0, 1'b1);
        send_sample(21845, -21846, 1'b0, 1'b1);
        send_sample(-21846, 21845, 1'b0, 1'b1);
        send_sample(255, -255, 1'b0, 1'b0);
        send_sample(383, -129, 1'b0, 1'b0);
        send_sample(-383, 129, 1'b1, 1'b0);
        send_sample(-32768, -32768, 1'b0, 1'b0);
        send_sample(32767, -1, 1'b0, 1'b0);
        // left held across the next register writes
        send_sample(1000, -1000, 1'b0, 1'b0);

        // Random phases, each under its own gain and byte order
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            write_register(sc8_pkg::REG_GAIN, ($urandom & 32'hFF00_0000) | 32'(phase_gain[p]));
            write_register(sc8_pkg::REG_SWAP, ($urandom & 32'hFFFF_FFFE) | 32'(phase_swap[p]));
            stream_samples(PHASE_LEN);
        end
        sample_ch.valid <= 1'b0;

        // Drain, then allow for the pipeline before judging
        for (int i = 0; i < 5000 && sb.pending_words.size() != 0; i++)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (sb.pending_words.size() != 0)
            sb.report_mismatch($sformatf("%0d expected words never came",
                                         sb.pending_words.size()));

        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
